/* hw/rtl/ibmp_pkg.sv */
// ---------------------------------------------------------------------------
// ibmp_pkg
// Shared types, constants and helpers of the indexed bitmap stream decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package ibmp_pkg;

    // Limits of the supported image.
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int POSITION_BITS = 24;

    // Fixed header layout.
    localparam int HEADER_END    = 50;
    localparam int MIN_HDR_SIZE  = 40;
    localparam int FILE_HDR_LEN  = 14;
    localparam int MAX_COLOURS   = 256;
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;

    // Output word kinds.
    localparam logic [1:0] KIND_COLOUR  = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes.
    localparam logic [2:0] ERR_NOT_BMP   = 3'd0;
    localparam logic [2:0] ERR_HEADER    = 3'd1;
    localparam logic [2:0] ERR_NOT_8BIT  = 3'd2;
    localparam logic [2:0] ERR_EMPTY     = 3'd3;
    localparam logic [2:0] ERR_COLOURS   = 3'd4;
    localparam logic [2:0] ERR_TRUNCATED = 3'd5;
    localparam logic [2:0] ERR_TOO_LARGE = 3'd6;
    localparam logic [2:0] ERR_OVERLAP   = 3'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] column;
        logic [11:0] row;
        logic [11:0] value;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [15:0] hot_x;
        logic [15:0] hot_y;
        logic [8:0]  colour_count;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out_word;

    // Words pushed into the output queue for one input byte.
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    // 8-bit channel to 4-bit nibble, (c + 8) / 17, by reciprocal multiply.
    function automatic logic [3:0] to_nibble(input logic [7:0] c);
        logic [8:0]  x;
        logic [20:0] p;
        begin
            x = {1'b0, c} + 9'd8;
            p = 21'(x) * 21'd3856;
            to_nibble = p[19:16];
        end
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ibmp_parse.sv */
// ---------------------------------------------------------------------------
// ibmp_parse
// Header capture and checks, palette and pixel tracking; forms up to two
// output words for each accepted input word.
// ---------------------------------------------------------------------------
`default_nettype none

module ibmp_parse
    import ibmp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_acc,
    input  wire t_in_word  i_word,
    output t_push          o_push,
    output t_out_word      o_res_a,
    output t_out_word      o_res_b
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // State
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [31:0] r_hot, n_hot;
    logic [31:0] r_pix_off, n_pix_off;
    logic [31:0] r_hsize, n_hsize;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [15:0] r_bpp, n_bpp;
    logic [31:0] r_comp, n_comp;
    logic [31:0] r_ncol, n_ncol;
    logic [15:0] r_gather, n_gather;
    logic [10:0] r_pal_cnt, n_pal_cnt;
    logic [12:0] r_col, n_col;
    logic [12:0] r_row, n_row;
    logic [3:0]  r_fail, n_fail;
    logic [POSITION_BITS-1:0] r_ps, n_ps;
    logic [POSITION_BITS-1:0] r_pe, n_pe;
    logic [POSITION_BITS-1:0] r_pix, n_pix;
    logic [33:0] r_data_end;

    // Derived image geometry
    logic [31:0] abs_rows;
    logic [12:0] width13, rows13, stride13;

    assign abs_rows = r_height[31] ? (~r_height + 32'd1) : r_height;
    assign width13  = r_width[12:0];
    assign rows13   = abs_rows[12:0];
    assign stride13 = (width13 + 13'd3) & ~13'd3;

    // End of pixel data, refreshed every cycle once geometry is stable
    always_ff @(posedge i_clk) begin
        r_data_end <= {2'b0, r_pix_off} + 34'(26'(stride13) * 26'(rows13 - 13'd1))
                      + 34'(width13);
    end

    // Next state and results
    always_comb begin
        logic [7:0]  b;
        logic [5:0]  p6;
        logic        hdr;
        logic [1:0]  ln;
        logic [8:0]  col_eff;
        logic [33:0] pe_full;
        logic [2:0]  code;
        logic        set;
        logic [1:0]  k;
        logic        data_v, eof_v, complete;
        t_out_word   dres, eres;

        b  = i_word.data_byte;
        p6 = r_pos[5:0];
        hdr = r_pos < POSITION_BITS'(HEADER_END);

        n_pos     = (r_pos < POS_MAX) ? r_pos + POSITION_BITS'(1) : r_pos;
        n_hot     = r_hot;
        n_pix_off = r_pix_off;
        n_hsize   = r_hsize;
        n_width   = r_width;
        n_height  = r_height;
        n_bpp     = r_bpp;
        n_comp    = r_comp;
        n_ncol    = r_ncol;
        n_gather  = r_gather;
        n_pal_cnt = r_pal_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_fail    = r_fail;
        n_ps      = r_ps;
        n_pe      = r_pe;
        n_pix     = r_pix;
        code      = ERR_NOT_BMP;
        set       = 1'b0;
        k         = 2'd0;
        data_v    = 1'b0;
        dres      = '0;
        eres      = '0;
        col_eff   = '0;
        pe_full   = '0;
        ln        = '0;

        // Header capture, little endian
        if (r_fail == 4'd0 && hdr) begin
            if (p6 >= 6'd6 && p6 <= 6'd9) begin
                ln = 2'(p6 - 6'd6);
                n_hot[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd10 && p6 <= 6'd13) begin
                ln = 2'(p6 - 6'd10);
                n_pix_off[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd14 && p6 <= 6'd17) begin
                ln = 2'(p6 - 6'd14);
                n_hsize[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd18 && p6 <= 6'd21) begin
                ln = 2'(p6 - 6'd18);
                n_width[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd22 && p6 <= 6'd25) begin
                ln = 2'(p6 - 6'd22);
                n_height[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd28 && p6 <= 6'd29) begin
                n_bpp[{p6[0], 3'b0} +: 8] = b;
            end else if (p6 >= 6'd30 && p6 <= 6'd33) begin
                ln = 2'(p6 - 6'd30);
                n_comp[{ln, 3'b0} +: 8] = b;
            end else if (p6 >= 6'd46 && p6 <= 6'd49) begin
                ln = 2'(p6 - 6'd46);
                n_ncol[{ln, 3'b0} +: 8] = b;
            end

            col_eff = (n_ncol == 32'd0) ? 9'(MAX_COLOURS) : n_ncol[8:0];
            pe_full = 34'(FILE_HDR_LEN) + {2'b0, n_hsize} + {23'b0, col_eff, 2'b0};

            // Header checks, first failure wins
            if (p6 == 6'd0) begin
                set = (b != SIG_B); code = ERR_NOT_BMP;
            end else if (p6 == 6'd1) begin
                set = (b != SIG_M); code = ERR_NOT_BMP;
            end else if (p6 == 6'd17) begin
                set = (n_hsize < 32'(MIN_HDR_SIZE)); code = ERR_HEADER;
            end else if (p6 == 6'd29) begin
                set = (n_bpp != 16'd8); code = ERR_NOT_8BIT;
            end else if (p6 == 6'd33) begin
                if (n_comp != 32'd0) begin
                    set = 1'b1; code = ERR_NOT_8BIT;
                end else if (r_width[31] || r_width == 32'd0 || abs_rows == 32'd0) begin
                    set = 1'b1; code = ERR_EMPTY;
                end else if (r_width > 32'(MAX_WIDTH) || abs_rows > 32'(MAX_HEIGHT)) begin
                    set = 1'b1; code = ERR_TOO_LARGE;
                end
            end else if (p6 == 6'd49) begin
                if (n_ncol > 32'(MAX_COLOURS)) begin
                    set = 1'b1; code = ERR_COLOURS;
                end else if (pe_full > 34'(POS_MAX) || r_data_end > 34'(POS_MAX)) begin
                    set = 1'b1; code = ERR_TOO_LARGE;
                end else if ({2'b0, r_pix_off} < pe_full) begin
                    set = 1'b1; code = ERR_OVERLAP;
                end
            end
            if (set) n_fail = {1'b0, code} + 4'd1;
            n_ps  = POSITION_BITS'(34'(FILE_HDR_LEN) + {2'b0, n_hsize});
            n_pe  = POSITION_BITS'(pe_full);
            n_pix = POSITION_BITS'(r_pix_off);
        end else if (r_fail == 4'd0) begin
            // Palette entries
            if (r_pos >= r_ps && r_pos < r_pe) begin
                k = r_pos[1:0] - r_ps[1:0];
                case (k)
                    2'd0: n_gather = {r_gather[15:8], b};
                    2'd1: n_gather = {b, r_gather[7:0]};
                    2'd2: begin
                        data_v = 1'b1;
                        dres.result_kind = KIND_COLOUR;
                        dres.column = {1'b0, r_pal_cnt};
                        dres.value = {to_nibble(b), to_nibble(r_gather[15:8]),
                                      to_nibble(r_gather[7:0])};
                    end
                    default: n_pal_cnt = r_pal_cnt + 11'd1;
                endcase
            // Pixel data, padding counted
            end else if (r_pos >= r_pix && r_row < rows13) begin
                if (r_col < width13) begin
                    data_v = 1'b1;
                    dres.result_kind = KIND_PIXEL;
                    dres.column = r_col[11:0];
                    dres.row = r_height[31] ? r_row[11:0]
                                            : 12'(rows13 - 13'd1 - r_row);
                    dres.value = {4'd0, b};
                end
                if (r_col + 13'd1 >= stride13) begin
                    n_col = '0;
                    n_row = r_row + 13'd1;
                end else begin
                    n_col = r_col + 13'd1;
                end
            end
        end

        // End of file: summary or error
        eof_v = i_word.end_of_file;
        complete = (n_row >= rows13) || ((n_row + 13'd1 == rows13) && (n_col >= width13));
        if (eof_v) begin
            if (n_fail == 4'd0 && r_pos == '0) begin
                n_fail = {1'b0, ERR_NOT_BMP} + 4'd1;
            end else if (n_fail == 4'd0 &&
                         (r_pos < POSITION_BITS'(HEADER_END - 1) || !complete)) begin
                n_fail = {1'b0, ERR_TRUNCATED} + 4'd1;
            end
        end
        if (n_fail != 4'd0) begin
            eres.result_kind = KIND_ERROR;
            eres.error_code  = 3'(n_fail - 4'd1);
        end else begin
            eres.result_kind  = KIND_SUMMARY;
            eres.image_width  = width13;
            eres.image_height = rows13;
            eres.hot_x        = r_hot[15:0];
            eres.hot_y        = r_hot[31:16];
            eres.colour_count = (r_ncol == 32'd0) ? 9'(MAX_COLOURS) : r_ncol[8:0];
        end
        eres.last_of_run = 1'b1;
        dres.last_of_run = !eof_v;

        if (eof_v) begin
            n_pos = '0; n_hot = '0; n_pix_off = '0; n_hsize = '0; n_width = '0;
            n_height = '0; n_bpp = '0; n_comp = '0; n_ncol = '0; n_gather = '0;
            n_pal_cnt = '0; n_col = '0; n_row = '0; n_fail = '0;
        end

        o_push.first  = i_acc && (data_v || eof_v);
        o_push.second = i_acc && data_v && eof_v;
        o_res_a = data_v ? dres : eres;
        o_res_b = eres;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_pal_cnt <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_fail    <= '0;
            r_hot     <= '0;
            r_pix_off <= '0;
            r_hsize   <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_bpp     <= '0;
            r_comp    <= '0;
            r_ncol    <= '0;
            r_gather  <= '0;
        end else if (i_acc) begin
            r_pos     <= n_pos;
            r_pal_cnt <= n_pal_cnt;
            r_col     <= n_col;
            r_row     <= n_row;
            r_fail    <= n_fail;
            r_hot     <= n_hot;
            r_pix_off <= n_pix_off;
            r_hsize   <= n_hsize;
            r_width   <= n_width;
            r_height  <= n_height;
            r_bpp     <= n_bpp;
            r_comp    <= n_comp;
            r_ncol    <= n_ncol;
            r_gather  <= n_gather;
        end
    end

    // Palette and pixel windows, fixed once the header passes
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_ps  <= n_ps;
            r_pe  <= n_pe;
            r_pix <= n_pix;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ibmp_outq.sv */
// ---------------------------------------------------------------------------
// ibmp_outq
// Four-entry output queue; takes up to two words a cycle, gives one unless the receiver stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module ibmp_outq
    import ibmp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_push     i_push,
    input  wire t_out_word i_res_a,
    input  wire t_out_word i_res_b,
    output logic           o_full,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_word      o_word
);

    t_out_word   r_mem [4];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_cnt, n_cnt;
    logic        pop;

    assign o_valid = (r_cnt != 3'd0);
    assign o_word  = r_mem[r_rd];
    assign pop     = o_valid && !i_stall;
    // Room for two words is guaranteed while at most two are held
    assign o_full  = (r_cnt > 3'd2);

    assign n_cnt = r_cnt + 3'(i_push.first) + 3'(i_push.second) - 3'(pop);

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + 2'(i_push.first) + 2'(i_push.second);
            r_rd  <= r_rd + 2'(pop);
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.first)  r_mem[r_wr] <= i_res_a;
        if (i_push.second) r_mem[r_wr + 2'd1] <= i_res_b;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("output queue overflow");
    a_two_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.second |-> (r_cnt <= 3'd2 && i_push.first)) else $error("double push without room");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.first) |=> (r_cnt == $past(r_cnt) - 3'd1))
        else $error("count did not drop on pop");

endmodule

`default_nettype wire

/* hw/rtl/indexed_bmp_stream_decoder_unit.sv */
// ---------------------------------------------------------------------------
// indexed_bmp_stream_decoder_unit
// Decodes an 8-bit indexed BMP byte stream into palette colours, pixels and
// an end-of-file summary or error.
//
//   channel | dir | handshake         | word
//   --------+-----+-------------------+------------------------------------
//   input   | in  | i_valid / o_stall | i_word (data_byte, end_of_file)
//   output  | out | o_valid / i_stall | o_word (kind, position, value, ...)
//
// One input word per cycle while o_stall is low; each word is handled in
// the cycle it is taken. A word gives zero, one or two output words (two
// on a final data byte); these go into a four-entry queue, and o_stall
// rises while it holds more than two. Output words leave one per cycle
// while i_stall is low. Reset is synchronous, active low; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_bmp_stream_decoder_unit
    import ibmp_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_word i_word,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_word     o_word
);

    logic      acc;
    logic      full;
    t_push     push;
    t_out_word res_a, res_b;

    assign o_stall = full;
    assign acc     = i_valid && !full;

    ibmp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_word  (i_word),
        .o_push  (push),
        .o_res_a (res_a),
        .o_res_b (res_b)
    );

    ibmp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res_a (res_a),
        .i_res_b (res_b),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

/* sim/ibmp_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ibmp_checker
// Watches both channels of the bitmap decoder, predicts the output words of
// every accepted input word and compares them in order with what comes out.
// ---------------------------------------------------------------------------
module ibmp_checker
    import ibmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_word,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [63:0] POS_LAST = (64'd1 << POSITION_BITS) - 64'd1;

    // decoder state as predicted
    logic [63:0] pos;
    logic [63:0] hdr [4];
    logic [15:0] gather;
    logic [10:0] pal_cnt;
    logic [31:0] col_cnt;
    logic [31:0] row_cnt;
    logic [3:0]  failed;

    t_out_word expected_words[$];

    function logic [63:0] hdr_size();
        return {32'd0, hdr[0][63:32]};
    endfunction

    function logic [63:0] pix_start();
        return {32'd0, hdr[0][31:0]};
    endfunction

    function logic [63:0] img_width();
        return {32'd0, hdr[1][31:0]};
    endfunction

    function logic [63:0] img_rows();
        logic [31:0] h;
        h = hdr[1][63:32];
        return h[31] ? {32'd0, 32'd0 - h} : {32'd0, h};
    endfunction

    function logic [63:0] num_colours();
        return (hdr[3][63:32] == 32'd0) ? 64'd256 : {32'd0, hdr[3][63:32]};
    endfunction

    function logic [63:0] row_stride();
        return (img_width() + 64'd3) & ~64'd3;
    endfunction

    function logic [63:0] palette_end();
        return 64'd14 + hdr_size() + 64'd4 * num_colours();
    endfunction

    function logic [3:0] chan_nibble(input logic [7:0] c);
        return 4'((32'(c) + 32'd8) / 32'd17);
    endfunction

    function void set_error(input logic [2:0] code);
        if (failed == 4'd0) failed = {1'b0, code} + 4'd1;
    endfunction

    function void clear_state();
        pos = '0;
        for (int i = 0; i < 4; i++) hdr[i] = '0;
        gather = '0;
        pal_cnt = '0;
        col_cnt = '0;
        row_cnt = '0;
        failed = '0;
    endfunction

    // header bytes land in the raw little-endian field store
    function void store_header(input int p, input logic [7:0] b);
        if (p >= 6 && p <= 9) hdr[2][(p-6)*8 +: 8] = b;
        else if (p >= 10 && p <= 17) hdr[0][(p-10)*8 +: 8] = b;
        else if (p >= 18 && p <= 25) hdr[1][(p-18)*8 +: 8] = b;
        else if (p >= 28 && p <= 29) hdr[2][32 + (p-28)*8 +: 8] = b;
        else if (p >= 30 && p <= 33) hdr[3][(p-30)*8 +: 8] = b;
        else if (p >= 46 && p <= 49) hdr[3][32 + (p-46)*8 +: 8] = b;
    endfunction

    function void header_checks(input int p, input logic [7:0] b);
        logic [63:0] data_end;
        if (p == 0 && b != SIG_B) set_error(ERR_NOT_BMP);
        else if (p == 1 && b != SIG_M) set_error(ERR_NOT_BMP);
        else if (p == 17 && hdr_size() < MIN_HDR_SIZE) set_error(ERR_HEADER);
        else if (p == 29 && hdr[2][47:32] != 16'd8) set_error(ERR_NOT_8BIT);
        else if (p == 33) begin
            if (hdr[3][31:0] != 32'd0) set_error(ERR_NOT_8BIT);
            else if (hdr[1][31] || img_width() == 0 || img_rows() == 0)
                set_error(ERR_EMPTY);
            else if (img_width() > MAX_WIDTH || img_rows() > MAX_HEIGHT)
                set_error(ERR_TOO_LARGE);
        end else if (p == 49) begin
            data_end = pix_start() + row_stride() * (img_rows() - 1) + img_width();
            if (num_colours() > MAX_COLOURS) set_error(ERR_COLOURS);
            else if (palette_end() > POS_LAST || data_end > POS_LAST)
                set_error(ERR_TOO_LARGE);
            else if (pix_start() < palette_end()) set_error(ERR_OVERLAP);
        end
    endfunction

    // one input word: queue the output words it causes
    function void decode_byte(input t_in_word w);
        logic [63:0] p;
        logic [63:0] ps;
        logic [7:0]  b;
        t_out_word   o;
        int          n0;
        logic        done;
        b = w.data_byte;
        p = pos;
        n0 = expected_words.size();
        if (failed == 4'd0) begin
            if (p < HEADER_END) begin
                store_header(int'(p), b);
                header_checks(int'(p), b);
            end else begin
                ps = 64'(FILE_HDR_LEN) + hdr_size();
                if (p >= ps && p < palette_end()) begin
                    case (2'(p - ps))
                        2'd0: gather[7:0] = b;
                        2'd1: gather[15:8] = b;
                        2'd2: begin
                            o = '0;
                            o.result_kind = KIND_COLOUR;
                            o.column = 12'(pal_cnt);
                            o.value = {chan_nibble(b), chan_nibble(gather[15:8]),
                                       chan_nibble(gather[7:0])};
                            expected_words.insert(expected_words.size(), o);
                        end
                        default: pal_cnt = pal_cnt + 11'd1;
                    endcase
                end else if (p >= pix_start() && 64'(row_cnt) < img_rows()) begin
                    if (64'(col_cnt) < img_width()) begin
                        o = '0;
                        o.result_kind = KIND_PIXEL;
                        o.column = 12'(col_cnt);
                        o.row = hdr[1][63] ? 12'(row_cnt)
                                           : 12'(img_rows() - 1 - 64'(row_cnt));
                        o.value = {4'd0, b};
                        expected_words.insert(expected_words.size(), o);
                    end
                    col_cnt++;
                    if (64'(col_cnt) >= row_stride()) begin
                        col_cnt = 0;
                        row_cnt++;
                    end
                end
            end
        end
        pos = (p < POS_LAST) ? p + 1 : p;
        if (w.end_of_file) begin
            done = (64'(row_cnt) >= img_rows()) ||
                   (64'(row_cnt) + 1 == img_rows() && 64'(col_cnt) >= img_width());
            if (p < 1) set_error(ERR_NOT_BMP);
            if (p < HEADER_END - 1 || !done) set_error(ERR_TRUNCATED);
            o = '0;
            if (failed != 4'd0) begin
                o.result_kind = KIND_ERROR;
                o.error_code = 3'(failed - 4'd1);
            end else begin
                o.result_kind = KIND_SUMMARY;
                o.image_width = 13'(img_width());
                o.image_height = 13'(img_rows());
                o.hot_x = hdr[2][15:0];
                o.hot_y = hdr[2][31:16];
                o.colour_count = 9'(num_colours());
            end
            expected_words.insert(expected_words.size(), o);
            clear_state();
        end
        if (expected_words.size() > n0)
            expected_words[expected_words.size()-1].last_of_run = 1'b1;
    endfunction

    assign o_pending = expected_words.size();

    // predict on input handshakes, compare on output handshakes
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            clear_state();
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%t unexpected word %p", $realtime, i_out_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.result_kind  !== i_out_word.result_kind  ||
                        want.column       !== i_out_word.column       ||
                        want.row          !== i_out_word.row          ||
                        want.value        !== i_out_word.value        ||
                        want.image_width  !== i_out_word.image_width  ||
                        want.image_height !== i_out_word.image_height ||
                        want.hot_x        !== i_out_word.hot_x        ||
                        want.hot_y        !== i_out_word.hot_y        ||
                        want.colour_count !== i_out_word.colour_count ||
                        want.error_code   !== i_out_word.error_code   ||
                        want.last_of_run  !== i_out_word.last_of_run) begin
                        if (o_fail_count < 10)
                            $display("%t mismatch: expected %p actual %p",
                                     $realtime, want, i_out_word);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) decode_byte(i_in_word);
        end
    end

endmodule

/* sim/tb_indexed_bmp_stream_decoder_unit.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_indexed_bmp_stream_decoder_unit
// Feeds generated BMP files, good and damaged, into the decoder under random
// input gaps and output stalls; the checker predicts and compares each word.
// ---------------------------------------------------------------------------
module tb_indexed_bmp_stream_decoder_unit;
    import ibmp_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    typedef enum int {
        F_GOOD, F_SIG, F_HDR, F_BITS, F_COMP, F_EMPTY, F_COLOURS,
        F_BIG, F_OVERLAP, F_TRUNC, F_NUM
    } t_flaw;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_word  i_word;
    logic      o_valid;
    logic      i_stall;
    t_out_word o_word;
    int        fail_count;
    int        pending;
    int        gap_pct;
    int        stall_pct;
    logic      hold_req;
    logic [7:0] file_bytes[$];

    indexed_bmp_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    ibmp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_word    (i_word),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_word   (o_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_left == 0) hold_left = 300;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb_indexed_bmp_stream_decoder_unit: errors");
                $finish;
            end
        end
    end

    task automatic put_le(input int at, input int n, input logic [31:0] v);
        for (int i = 0; i < n; i++) file_bytes[at+i] = v[i*8 +: 8];
    endtask

    // build one file, optionally with one flaw
    task automatic build_file(input t_flaw flaw, input int w, input int h_abs,
                              input int ncol);
        int hsize, colf, pal_n, offs, stride, total;
        logic [31:0] h;
        hsize = 40 + $urandom_range(3);
        pal_n = (ncol == 0) ? 256 : ncol;
        colf = ncol;
        offs = 14 + hsize + 4 * pal_n + $urandom_range(2);
        stride = (w + 3) & ~3;
        h = $urandom_range(1) ? 32'd0 - 32'(h_abs) : 32'(h_abs);
        total = offs + stride * (h_abs - 1) + w + $urandom_range(2);
        file_bytes.delete();
        for (int i = 0; i < total; i++) file_bytes.push_back(8'($urandom));
        file_bytes[0] = SIG_B;
        file_bytes[1] = SIG_M;
        put_le(10, 4, offs);
        put_le(14, 4, hsize);
        put_le(18, 4, w);
        put_le(22, 4, h);
        put_le(28, 2, 8);
        put_le(30, 4, 0);
        put_le(46, 4, colf);
        case (flaw)
            F_SIG:     file_bytes[$urandom_range(1)] = 8'($urandom_range(255));
            F_HDR:     put_le(14, 4, $urandom_range(39));
            F_BITS:    put_le(28, 2, $urandom_range(1) ? 24 : 16'($urandom));
            F_COMP:    put_le(30, 4, 1 + $urandom_range(3));
            F_EMPTY:   case ($urandom_range(2))
                           0: put_le(18, 4, 0);
                           1: put_le(18, 4, 32'hFFFF_FFFF - $urandom_range(9));
                           default: put_le(22, 4, 0);
                       endcase
            F_COLOURS: put_le(46, 4, 257 + $urandom_range(1000));
            F_BIG:     if ($urandom_range(1)) put_le(18, 4, 4097 + $urandom_range(99));
                       else put_le(10, 4, 32'hFFFF_FF00);
            F_OVERLAP: put_le(10, 4, $urandom_range(14 + hsize + 4 * pal_n - 1));
            F_TRUNC:   repeat (1 + $urandom_range(total - 2)) void'(file_bytes.pop_back());
            default: ;
        endcase
    endtask

    // send the current file word by word
    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            while ($urandom_range(99) < gap_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_word <= '{data_byte: file_bytes[i],
                        end_of_file: (i == file_bytes.size() - 1)};
            do @(posedge i_clk); while (o_stall);
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        t_flaw flaw;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_word = '0;
        hold_req = 1'b0;
        gap_pct = 28;
        stall_pct = 66;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: very short files
        file_bytes = '{8'h42};
        send_file();
        file_bytes = '{8'hBD};
        send_file();
        file_bytes = '{SIG_B, SIG_M};
        send_file();
        file_bytes = '{SIG_B, 8'h00, 8'hFF};
        send_file();
        // small clean file
        build_file(F_GOOD, 1, 1, 1);
        send_file();

        // random part, three idling phases
        for (int n = 0; n < 6; n++) begin
            if (n == 2 || n == 4) begin
                drain();
                gap_pct = (n == 2) ? 66 : 0;
                stall_pct = (n == 2) ? 28 : 0;
            end
            if ($urandom_range(99) < 55) flaw = F_GOOD;
            else flaw = t_flaw'($urandom_range(F_NUM - 1));
            if (n == 5) begin
                // long receiver hold-off over a clean file of four by two pixels
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
                build_file(F_GOOD, 4, 2, 2);
            end else begin
                build_file(flaw, 1 + $urandom_range(3), 1 + $urandom_range(1),
                           1 + $urandom_range(1));
            end
            send_file();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_indexed_bmp_stream_decoder_unit: clean");
        else
            $display("tb_indexed_bmp_stream_decoder_unit: errors");
        $finish;
    end

endmodule
